// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, opcodes and status codes of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEFAULT_DEPTH = 1024;

    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- rtl/deq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of 32-bit words with push, pop and peek at both ends.
// ----------------------------------------------------------------------------
// Each accepted word carries an opcode and a push value and yields exactly one
// result word with a status, the word read by a pop or peek (zero otherwise or
// on error) and the occupancy after the operation. The words live in one
// DEPTH-entry RAM with a registered read port; head, tail and occupancy sit in
// flip-flops. An operation runs in two steps: in the accept cycle the indices
// and count update and the RAM is written (push) or addressed (pop/peek); in
// the next cycle the read data lands in the output register. A new word is not
// accepted while one is in flight behind the registered RAM read, and a new
// word is taken in the cycle the previous result is handed off. The store has
// no reset: entries are only read after they are written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [deq_pkg::STATUS_W-1:0]        status,
    output logic signed [deq_pkg::WORD_W-1:0]   read_value,
    output logic [deq_pkg::COUNT_W-1:0]         count
);

    import deq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    // Control state
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                pend_reg;
    logic                out_valid_reg;

    // Result held across the RAM read
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_use_rd_reg, pend_use_rd_next;
    logic [COUNT_W-1:0]  pend_count_reg;

    // Output register
    logic [STATUS_W-1:0] status_reg;
    logic [WORD_W-1:0]   read_value_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic                accept;
    logic                is_empty, is_full;
    logic [IDX_W-1:0]    head_inc, head_dec, tail_inc, tail_dec;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    logic [OCC_W+COUNT_W-1:0] occ_ext;

    // Take a new word only with nothing in flight and the output slot free
    // or being emptied this cycle.
    assign in_ready = !pend_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == OCC_FULL);

    // Ring index neighbors, wrapping at DEPTH
    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;

    // Decode the operation against the current indices
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        pend_status_next = ST_OK;
        pend_use_rd_next = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = tail_reg;
        ram_raddr        = head_reg;
        case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    ram_we   = accept;
                    occ_next = occ_reg + 1'b1;
                    if (opcode == OP_PUSH_FRONT)
                    begin
                        head_next = head_dec;
                        ram_waddr = head_dec;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        ram_waddr = tail_reg;
                    end
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT:
            begin
                ram_raddr = head_reg;
                if (is_empty)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                    if (opcode == OP_POP_FRONT)
                    begin
                        head_next = head_inc;
                        occ_next  = occ_reg - 1'b1;
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK:
            begin
                ram_raddr = tail_dec;
                if (is_empty)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                    if (opcode == OP_POP_BACK)
                    begin
                        tail_next = tail_dec;
                        occ_next  = occ_reg - 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                occ_next  = '0;
            end
            default:
            begin
                // unused opcode: no operation
            end
        endcase
    end

    // Mask the occupancy to the count field width
    assign occ_ext = (OCC_W + COUNT_W)'(occ_next);

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_value),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
            pend_reg <= accept;
            // Advance the pending result into the output slot; drop it on handoff
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= pend_status_next;
            pend_use_rd_reg <= pend_use_rd_next;
            pend_count_reg  <= occ_ext[COUNT_W-1:0];
        end
        if (pend_reg)
        begin
            status_reg     <= pend_status_reg;
            read_value_reg <= pend_use_rd_reg ? ram_rdata : '0;
            count_reg      <= pend_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;

endmodule
